// ===== rtl/lcs_pkg.sv =====
package lcs_pkg;

	// defaults for the top-level parameters
	localparam int MAX_LEN_DEF   = 64;
	localparam int ELEM_BITS_DEF = 32;

	// width of the length registers and of every table value
	localparam int LEN_W = 7;

	// configuration register map
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_B = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_DRAIN
	} lcs_state_t;

	// control handed to the cell unit along with the operands
	typedef struct packed {
		logic valid;
		logic first_col;
		logic first_row;
	} lcs_cell_ctl_t;

endpackage

// ===== rtl/lcs_ifs.sv =====
interface lcs_elem_if import lcs_pkg::*; #(
	parameter int ElemBits = ELEM_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic signed [ElemBits-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface lcs_result_if import lcs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] lcs_length;

	modport source (output valid, output lcs_length, input ready);
	modport sink (input valid, input lcs_length, output ready);
endinterface

interface lcs_cfg_if import lcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEN_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lcs_ram.sv =====
module lcs_ram #(
	parameter int Width = 8,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lcs_cell_unit.sv =====
module lcs_cell_unit import lcs_pkg::*; #(
	parameter int ElemBits = ELEM_BITS_DEF
) (
	input  logic                clk,
	input  lcs_cell_ctl_t       ctl,
	input  logic [ElemBits-1:0] a_val,
	input  logic [ElemBits-1:0] b_val,
	input  logic [LEN_W-1:0]    up_raw,
	output logic [LEN_W-1:0]    cell_out
);

	logic [LEN_W-1:0] left_q;
	logic [LEN_W-1:0] diag_q;
	logic [LEN_W-1:0] up;
	logic [LEN_W-1:0] left;
	logic [LEN_W-1:0] diag;

	// row above the first and column left of the first read as zero
	always_comb begin
		up   = ctl.first_row ? '0 : up_raw;
		left = ctl.first_col ? '0 : left_q;
		diag = ctl.first_col ? '0 : diag_q;
		if (a_val == b_val) begin
			cell_out = LEN_W'(diag + 1'b1);
		end else begin
			cell_out = (up > left) ? up : left;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			left_q <= cell_out;
			diag_q <= up;
		end
	end

endmodule

// ===== rtl/lcs_length_engine_top.sv =====
// lcs length engine: length of the longest common subsequence of two sequences
// loading takes one element per cycle while element ready is high; the last b element starts the table walk
// compute walks the table one cell per cycle through one shared compare/max unit, with a
// drain state after each row; the result register loads during the drain of the last row
// element ready stays low during compute; the next load can start while a result waits
// reset clears control state and sets both lengths to 1; the element stores are not cleared
module lcs_length_engine_top import lcs_pkg::*; #(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	lcs_elem_if.sink      elem,
	lcs_result_if.source  result,
	lcs_cfg_if.sink       cfg
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;       // element store address
	localparam int DW = $clog2(MAX_LEN + 1);                         // dp row address
	localparam int CW = LEN_W + 1;                                   // load counter

	// configuration registers, raw bits as written
	logic [LEN_W-1:0] length_a_q;
	logic [LEN_W-1:0] length_b_q;

	// effective lengths after clamping
	logic [LEN_W-1:0] la;
	logic [LEN_W-1:0] lb;
	logic [CW-1:0]    total;

	// sequencer state
	lcs_state_t       state_q;
	lcs_state_t       state_d;
	logic [CW-1:0]    load_cnt_q;
	logic [LEN_W-1:0] row_q;
	logic [LEN_W-1:0] col_q;

	// execute stage of the cell pipeline
	logic             ex_v_s1;
	logic [LEN_W-1:0] ex_col_s1;

	// output register
	logic             out_valid_q;
	logic [LEN_W-1:0] out_data_q;

	logic elem_xfer;
	logic a_phase;
	logic last_elem;
	logic row_done;
	logic last_row;

	logic [ELEM_BITS-1:0] a_rdata;
	logic [ELEM_BITS-1:0] b_rdata;
	logic [LEN_W-1:0]     dp_rdata;
	logic [LEN_W-1:0]     cell_val;
	logic [AW-1:0]        b_waddr;
	lcs_cell_ctl_t        cell_ctl;

	// a length of zero means one, anything beyond the store depth means the depth
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] v;
		v = raw;
		if (raw == '0) begin
			v = LEN_W'(1);
		end else if (int'(raw) > MAX_LEN) begin
			v = LEN_W'(MAX_LEN);
		end
		return v;
	endfunction

	assign la    = eff_len(length_a_q);
	assign lb    = eff_len(length_b_q);
	assign total = CW'(la) + CW'(lb);

	// configuration writes, never stalled
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_a_q <= LEN_W'(1);
			length_b_q <= LEN_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LENGTH_A: length_a_q <= cfg.data;
				CFG_LENGTH_B: length_b_q <= cfg.data;
				default: ;  // indexes beyond the map are dropped
			endcase
		end
	end

	// load phase decode: a entries first, then b; the final element
	// (or anything past it after a length change) lands in the last b entry
	assign a_phase   = load_cnt_q < CW'(la);
	assign last_elem = !a_phase &&
		!(((CW + 1)'(load_cnt_q) + (CW + 1)'(1)) < (CW + 1)'(total));

	// hold off the final element while an earlier result still waits
	assign elem.ready = (state_q == ST_LOAD) && !(last_elem && out_valid_q);
	assign elem_xfer  = elem.valid && elem.ready;

	assign b_waddr = last_elem ? AW'(lb - LEN_W'(1)) : AW'(load_cnt_q - CW'(la));

	assign row_done = (col_q == lb);
	assign last_row = (row_q == LEN_W'(la - LEN_W'(1)));

	// next state: RUN issues one cell per cycle, DRAIN lets the last cell of a row finish
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (elem_xfer && last_elem) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (row_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = last_row ? ST_LOAD : ST_RUN;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// load counter, row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= LEN_W'(1);
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (elem_xfer) begin
						if (last_elem) begin
							load_cnt_q <= '0;
							row_q      <= '0;
							col_q      <= LEN_W'(1);
						end else begin
							load_cnt_q <= CW'(load_cnt_q + 1'b1);
						end
					end
				end
				ST_RUN: begin
					if (!row_done) begin
						col_q <= LEN_W'(col_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					if (!last_row) begin
						row_q <= LEN_W'(row_q + 1'b1);
						col_q <= LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// execute stage follows each issued cell in the next cycle (store read latency)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_v_s1 <= 1'b0;
		end else begin
			ex_v_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		ex_col_s1 <= col_q;
	end

	// result register: the last cell of the last row is the answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DRAIN && last_row) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && last_row) begin
			out_data_q <= cell_val;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.lcs_length = out_data_q;

	// sequence a store, read at the current row
	lcs_ram #(
		.Width (ELEM_BITS),
		.Depth (MAX_LEN)
	) u_seq_a (
		.clk   (clk),
		.we    (elem_xfer && a_phase),
		.waddr (AW'(load_cnt_q)),
		.wdata (elem.element_value),
		.raddr (AW'(row_q)),
		.rdata (a_rdata)
	);

	// sequence b store, read at column - 1
	lcs_ram #(
		.Width (ELEM_BITS),
		.Depth (MAX_LEN)
	) u_seq_b (
		.clk   (clk),
		.we    (elem_xfer && !a_phase),
		.waddr (b_waddr),
		.wdata (elem.element_value),
		.raddr (AW'(col_q - LEN_W'(1))),
		.rdata (b_rdata)
	);

	// one dp row; entry 0 is never touched, the first row masks the reads
	// so no clearing pass is needed before a compute
	lcs_ram #(
		.Width (LEN_W),
		.Depth (MAX_LEN + 1)
	) u_dp_row (
		.clk   (clk),
		.we    (ex_v_s1),
		.waddr (DW'(ex_col_s1)),
		.wdata (cell_val),
		.raddr (DW'(col_q)),
		.rdata (dp_rdata)
	);

	assign cell_ctl.valid     = ex_v_s1;
	assign cell_ctl.first_col = (ex_col_s1 == LEN_W'(1));
	assign cell_ctl.first_row = (row_q == '0);

	// shared cell evaluator: match -> diagonal + 1, else max of up and left
	lcs_cell_unit #(
		.ElemBits (ELEM_BITS)
	) u_cell (
		.clk      (clk),
		.ctl      (cell_ctl),
		.a_val    (a_rdata),
		.b_val    (b_rdata),
		.up_raw   (dp_rdata),
		.cell_out (cell_val)
	);

endmodule

// ===== tb/lcs_result_check.sv =====
module lcs_result_check import lcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lcs_elem_if         elem,
	lcs_result_if       result,
	lcs_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	logic [LEN_W-1:0]         len_a_reg;
	logic [LEN_W-1:0]         len_b_reg;
	logic [ELEM_BITS_DEF-1:0] seq_a [MAX_LEN_DEF];
	logic [ELEM_BITS_DEF-1:0] seq_b [MAX_LEN_DEF];
	int unsigned              load_count;
	int unsigned              errors = 0;
	logic [LEN_W-1:0]         expected_lengths [$];

	// zero reads as one, anything past the top reads as the top
	function automatic int unsigned clamp_len(input logic [LEN_W-1:0] r);
		if (r == '0)
			return 1;
		if (r > MAX_LEN_DEF)
			return MAX_LEN_DEF;
		return r;
	endfunction

	// bottom-up lcs over one row of lb+1 cells
	function automatic logic [LEN_W-1:0] lcs_of_stores(input int unsigned la,
			input int unsigned lb);
		logic [LEN_W-1:0] row [MAX_LEN_DEF+1];
		logic [LEN_W-1:0] diag;
		logic [LEN_W-1:0] up;
		logic [LEN_W-1:0] left;
		logic [LEN_W-1:0] cell_val;
		for (int c = 0; c <= MAX_LEN_DEF; c++)
			row[c] = '0;
		for (int r = 0; r < la; r++) begin
			diag = '0;
			for (int c = 1; c <= lb; c++) begin
				up   = row[c];
				left = row[c-1];
				if (seq_a[r] == seq_b[c-1])
					cell_val = diag + 1'b1;
				else
					cell_val = (up > left) ? up : left;
				diag   = up;
				row[c] = cell_val;
			end
		end
		return row[lb];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned      la;
		int unsigned      lb;
		logic [LEN_W-1:0] want;
		if (!arst_n) begin
			len_a_reg  = LEN_W'(1);
			len_b_reg  = LEN_W'(1);
			load_count = 0;
			expected_lengths.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_lengths.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("tb: lcs_length %0d with no load pending", result.lcs_length);
				end else begin
					want = expected_lengths.pop_front();
					if (result.lcs_length !== want) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("tb: lcs_length mismatch: expected %0d, got %0d",
								want, result.lcs_length);
					end
				end
			end
			// an element at the same edge as a register write still sees the old lengths
			if (elem.valid && elem.ready) begin
				la = clamp_len(len_a_reg);
				lb = clamp_len(len_b_reg);
				if (load_count < la) begin
					seq_a[load_count] = elem.element_value;
					load_count++;
				end else if (load_count + 1 < la + lb) begin
					seq_b[load_count - la] = elem.element_value;
					load_count++;
				end else begin
					seq_b[lb - 1] = elem.element_value;
					load_count = 0;
					expected_lengths.push_back(lcs_of_stores(la, lb));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_LENGTH_A: len_a_reg = cfg.data;
					CFG_LENGTH_B: len_b_reg = cfg.data;
					default: ;
				endcase
			end
		end
		fail_count <= errors;
		pending    <= expected_lengths.size();
	end

endmodule

// ===== tb/tb.sv =====
module tb import lcs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS    = 1220;
	localparam int CALM_ITEMS     = 1100;
	localparam int SETTLE_CYCLES  = 8;
	// slowest gap: a 64 x 64 table walk plus a result stall, taken several times
	localparam int WATCHDOG_LIMIT = 25000;

	localparam logic [CFG_IDX_W-1:0] STRAY_IDX_TOP = {CFG_IDX_W{1'b1}};
	localparam logic [LEN_W-1:0]     LEN_REG_TOP   = {LEN_W{1'b1}};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        calm;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned fail_count;
	int unsigned pending;

	lcs_elem_if #(.ElemBits(ELEM_BITS_DEF)) elem_ch ();
	lcs_result_if                           result_ch ();
	lcs_cfg_if                              cfg_ch ();

	lcs_length_engine_top #(
		.MAX_LEN   (MAX_LEN_DEF),
		.ELEM_BITS (ELEM_BITS_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	lcs_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem       (elem_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// no idling in the last stretch of the run
	assign calm = (items_sent >= CALM_ITEMS);

	// result side: ready drops low in random bursts
	initial begin
		int n;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// watchdog: cycles in a row with no transfer on any channel
	always @(posedge clk) begin
		if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// one element transfer, now and then with a random gap in front of it
	// valid is left high so back-to-back elements need no lowering
	task automatic send_elem(input logic [ELEM_BITS_DEF-1:0] value);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			elem_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_ch.valid         <= 1'b1;
		elem_ch.element_value <= value;
		@(posedge clk);
		while (!elem_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// one register transfer; the caller lowers valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [LEN_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// wait until every predicted length has come back, then let the block go quiet
	// the first edge lets the predictor's count catch up with the last transfer
	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// program both lengths while idle, then run a number of complete loads
	task automatic run_phase(input logic [LEN_W-1:0] a_reg, input logic [LEN_W-1:0] b_reg,
			input int loads);
		int unsigned              la;
		int unsigned              lb;
		int unsigned              n_colors;
		logic [ELEM_BITS_DEF-1:0] colors [8];
		// lengths as the block reads them
		la = (a_reg == '0) ? 1 : ((a_reg > MAX_LEN_DEF) ? MAX_LEN_DEF : a_reg);
		lb = (b_reg == '0) ? 1 : ((b_reg > MAX_LEN_DEF) ? MAX_LEN_DEF : b_reg);
		settle();
		write_reg(CFG_LENGTH_A, a_reg);
		write_reg(CFG_LENGTH_B, b_reg);
		// now and then a write past the register map, which must change nothing
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(CFG_LENGTH_B + 1, STRAY_IDX_TOP)),
				LEN_W'($urandom));
		cfg_ch.valid <= 1'b0;
		repeat (loads) begin
			// small alphabet per load so matches are common and lengths vary
			n_colors = $urandom_range(1, 8);
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(0, 7))
					0: colors[i] = {1'b1, {(ELEM_BITS_DEF-1){1'b0}}};
					1: colors[i] = {1'b0, {(ELEM_BITS_DEF-1){1'b1}}};
					2: colors[i] = '0;
					3: colors[i] = '1;
					// one bit away from the first symbol: full-width compare
					4: colors[i] = (i == 0) ? ELEM_BITS_DEF'($urandom)
						: colors[0] ^ (ELEM_BITS_DEF'(1) << $urandom_range(0, ELEM_BITS_DEF - 1));
					default: colors[i] = ELEM_BITS_DEF'($urandom);
				endcase
			end
			for (int k = 0; k < la + lb; k++) begin
				if ($urandom_range(0, 15) == 0)
					send_elem(ELEM_BITS_DEF'($urandom));
				else
					send_elem(colors[$urandom_range(0, n_colors - 1)]);
			end
		end
		elem_ch.valid <= 1'b0;
	endtask

	initial begin
		// every block input known from time zero
		arst_n                <= 1'b0;
		elem_ch.valid         <= 1'b0;
		elem_ch.element_value <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= CFG_LENGTH_A;
		cfg_ch.data           <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lengths straight out of reset, one and one: most negative pair matches,
		// zero against all ones does not
		send_elem(32'h8000_0000);
		send_elem(32'h8000_0000);
		send_elem(32'h0000_0000);
		send_elem(32'hffff_ffff);
		elem_ch.valid <= 1'b0;

		// zero lengths read as one; a write past the map is ignored
		settle();
		write_reg(CFG_LENGTH_A, '0);
		write_reg(CFG_LENGTH_B, '0);
		write_reg(STRAY_IDX_TOP, LEN_REG_TOP);
		cfg_ch.valid <= 1'b0;
		send_elem(32'h7fff_ffff);
		send_elem(32'h7fff_ffff);
		elem_ch.valid <= 1'b0;

		// a = 1 2 3, b = 3 1 2 3: whole of a is common
		settle();
		write_reg(CFG_LENGTH_A, LEN_W'(3));
		write_reg(CFG_LENGTH_B, LEN_W'(4));
		cfg_ch.valid <= 1'b0;
		send_elem(32'd1);
		send_elem(32'd2);
		send_elem(32'd3);
		send_elem(32'd3);
		send_elem(32'd1);
		send_elem(32'd2);
		send_elem(32'd3);
		elem_ch.valid <= 1'b0;

		// all ones and most positive differ only in the sign bit
		settle();
		write_reg(CFG_LENGTH_A, LEN_W'(2));
		write_reg(CFG_LENGTH_B, LEN_W'(5));
		cfg_ch.valid <= 1'b0;
		send_elem(32'hffff_ffff);
		send_elem(32'h7fff_ffff);
		send_elem(32'h0000_0000);
		send_elem(32'hffff_ffff);
		send_elem(32'd5);
		send_elem(32'h7fff_ffff);
		send_elem(32'hffff_ffff);
		elem_ch.valid <= 1'b0;

		// length extremes: past the top on both, the top against zero, one against the top
		run_phase(LEN_REG_TOP, LEN_REG_TOP, 1);
		run_phase(LEN_W'(MAX_LEN_DEF), '0, 1);
		run_phase(LEN_W'(1), LEN_W'(MAX_LEN_DEF), 2);

		// random phases, mostly short sequences so the table walks stay quick
		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 15))
				0: run_phase(LEN_W'($urandom_range(MAX_LEN_DEF, LEN_REG_TOP)),
					LEN_W'($urandom_range(40, LEN_REG_TOP)), 1);
				1: run_phase('0, LEN_W'($urandom_range(0, 12)), $urandom_range(1, 6));
				2: run_phase(LEN_W'($urandom_range(0, LEN_REG_TOP)),
					LEN_W'($urandom_range(0, 4)), $urandom_range(1, 3));
				3: run_phase(LEN_W'($urandom_range(9, 32)), LEN_W'($urandom_range(9, 32)), 1);
				default: run_phase(LEN_W'($urandom_range(1, 8)), LEN_W'($urandom_range(1, 8)),
					$urandom_range(1, 6));
			endcase
		end

		// drain the last results and give the verdict
		settle();
		if (fail_count == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
